// File: rtl/core/cpjs_pkg.sv
// ----------------------------------------------------------------------------
// cpjs_pkg
// Shared types, widths and constants of the column pair divergence block.
// ----------------------------------------------------------------------------
package cpjs_pkg;

   // Default storage size and value format.
   localparam int MAX_ROWS_DEF = 1024;
   localparam int MAX_COLS_DEF = 64;
   localparam int FRAC_BITS    = 24;

   // Field and register widths.
   localparam int VALUE_W    = 48;
   localparam int ROWS_W     = 11;
   localparam int COLS_W     = 7;
   localparam int PSEUDO_W   = 24;
   localparam int ROW_IDX_W  = 10;
   localparam int COL_IDX_W  = 6;
   localparam int DIV_OUT_W  = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Datapath widths.
   localparam int SUM_W      = 64;
   localparam int NUM_W      = VALUE_W + 1;
   localparam int PROB_W     = 33;
   localparam int PSUM_W     = 34;
   localparam int LOG_W      = 38;
   localparam int MUL_A_W    = 33;
   localparam int MUL_HALF_W = 20;
   localparam int MUL_PP_W   = MUL_A_W + MUL_HALF_W;
   localparam int PROD_W     = 73;
   localparam int ACC_W      = 64;
   localparam int DIFF_W     = 40;

   // Register reset values.
   localparam logic [ROWS_W-1:0]   ROWS_RESET   = ROWS_W'(1024);
   localparam logic [COLS_W-1:0]   COLS_RESET   = COLS_W'(64);
   localparam logic [PSEUDO_W-1:0] PSEUDO_RESET =
      PSEUDO_W'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

   // ln(2) in Q0.32.
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   typedef enum logic {
      CMD_LOAD,
      CMD_QUERY
   } cmd_type;

   typedef enum logic {
      STATUS_OK,
      STATUS_RANGE
   } status_type;

   typedef enum logic [1:0] {
      CSR_ROWS,
      CSR_COLS,
      CSR_PSEUDO
   } csr_index_type;

   typedef enum logic [1:0] {
      MATH_DIV,
      MATH_LOG,
      MATH_MUL
   } math_op_type;

   typedef enum logic [2:0] {
      M_IDLE,
      M_DIV,
      M_NORM,
      M_SQR,
      M_MUL_HI
   } math_phase_type;

   typedef struct packed {
      logic        start;
      math_op_type op;
   } math_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } math_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_SUM_RD_A,
      S_SUM_RD_B,
      S_SUM_CAP,
      S_P2_RD_A,
      S_P2_RD_B,
      S_P2_CAP,
      S_DIV_GO,
      S_DIV_WAIT,
      S_LOGS_GO,
      S_LOGS_WAIT,
      S_TERM_GO,
      S_TERM_LOG_WAIT,
      S_TERM_MUL_WAIT,
      S_ROW_NEXT,
      S_FIN_GO,
      S_FIN_WAIT,
      S_RESULT
   } state_type;

endpackage

// File: rtl/core/cpjs_ram.sv
// ----------------------------------------------------------------------------
// cpjs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cpjs_ram #(
   parameter int WIDTH = cpjs_pkg::VALUE_W,
   parameter int DEPTH = cpjs_pkg::MAX_ROWS_DEF * cpjs_pkg::MAX_COLS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/cpjs_math.sv
// ----------------------------------------------------------------------------
// cpjs_math
// Shared multicycle arithmetic unit: Q0.32 divider, base-2 logarithm by
// repeated squaring, and a 33 x 40 multiplier built from two partial products.
// ----------------------------------------------------------------------------
module cpjs_math (
   input  logic                        clock,
   input  logic                        reset,
   input  cpjs_pkg::math_req_type      req,
   input  logic [cpjs_pkg::SUM_W-1:0]  opa,
   input  logic [cpjs_pkg::SUM_W-1:0]  opb,
   output cpjs_pkg::math_rsp_type      rsp,
   output logic [cpjs_pkg::PROD_W-1:0] result
);

   import cpjs_pkg::*;

   math_phase_type phase_ff, phase_in;
   logic done_ff, done_in;
   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] den_ff, den_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [PSUM_W-1:0] lx_ff, lx_in;
   logic [5:0] le_ff, le_in;
   logic [31:0] y_ff, y_in;
   logic [31:0] frac_ff, frac_in;
   logic [MUL_A_W-1:0] ma_ff, ma_in;
   logic [MUL_HALF_W-1:0] mb_hi_ff, mb_hi_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PROD_W-1:0] res_ff, res_in;

   logic [SUM_W-1:0] div_sh;
   logic div_take;
   logic [SUM_W-1:0] rem_next;
   logic [31:0] quo_next;
   logic [63:0] sq;
   logic [32:0] yn;
   logic [31:0] frac_next;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_HALF_W-1:0] mul_b;
   logic [MUL_PP_W-1:0] pp;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         M_IDLE: begin
            if (req.start) begin
               unique case (req.op)
                  MATH_DIV: phase_in = (opa >= opb) ? M_IDLE : M_DIV;
                  MATH_LOG: phase_in = M_NORM;
                  MATH_MUL: phase_in = M_MUL_HI;
                  default:  phase_in = M_IDLE;
               endcase
            end
         end
         M_DIV:    phase_in = (cnt_ff == 6'd1) ? M_IDLE : M_DIV;
         M_NORM:   phase_in = lx_ff[PSUM_W-1] ? M_SQR : M_NORM;
         M_SQR:    phase_in = (cnt_ff == 6'd1) ? M_IDLE : M_SQR;
         M_MUL_HI: phase_in = M_IDLE;
         default:  phase_in = M_IDLE;
      endcase
   end

   // Status outputs.
   always_comb begin
      rsp.busy = (phase_ff != M_IDLE);
      rsp.done = done_ff;
      result   = res_ff;
   end

   // One restoring division step, one squaring step, one partial product.
   always_comb begin
      div_sh    = {rem_ff[SUM_W-2:0], 1'b0};
      div_take  = rem_ff[SUM_W-1] || (div_sh >= den_ff);
      rem_next  = div_take ? (div_sh - den_ff) : div_sh;
      quo_next  = {quo_ff[30:0], div_take};
      sq        = 64'(y_ff) * 64'(y_ff);
      yn        = sq[63:31];
      frac_next = {frac_ff[30:0], yn[32]};
      mul_a     = (phase_ff == M_IDLE) ? opa[MUL_A_W-1:0] : ma_ff;
      mul_b     = (phase_ff == M_IDLE) ? opb[MUL_HALF_W-1:0] : mb_hi_ff;
      pp        = MUL_PP_W'(mul_a) * MUL_PP_W'(mul_b);
   end

   // Datapath register updates.
   always_comb begin
      done_in  = 1'b0;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      lx_in    = lx_ff;
      le_in    = le_ff;
      y_in     = y_ff;
      frac_in  = frac_ff;
      ma_in    = ma_ff;
      mb_hi_in = mb_hi_ff;
      prod_in  = prod_ff;
      res_in   = res_ff;
      unique case (phase_ff)
         M_IDLE: begin
            if (req.start) begin
               unique case (req.op)
                  MATH_DIV: begin
                     if (opa >= opb) begin
                        // A share of the whole is exactly one.
                        res_in  = PROD_W'(64'h1_0000_0000);
                        done_in = 1'b1;
                     end else begin
                        rem_in = opa;
                        den_in = opb;
                        quo_in = '0;
                        cnt_in = 6'd32;
                     end
                  end
                  MATH_LOG: begin
                     lx_in = opa[PSUM_W-1:0];
                     le_in = 6'(PSUM_W - 1);
                  end
                  MATH_MUL: begin
                     prod_in  = PROD_W'(pp);
                     ma_in    = opa[MUL_A_W-1:0];
                     mb_hi_in = opb[2*MUL_HALF_W-1:MUL_HALF_W];
                  end
                  default: begin
                     done_in = 1'b0;
                  end
               endcase
            end
         end
         M_DIV: begin
            rem_in = rem_next;
            quo_in = quo_next;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               res_in  = PROD_W'(quo_next);
               done_in = 1'b1;
            end
         end
         M_NORM: begin
            // Shift the leading one to the top, a byte at a time where possible.
            if (lx_ff[PSUM_W-1]) begin
               y_in    = lx_ff[PSUM_W-1:2];
               frac_in = '0;
               cnt_in  = 6'd32;
            end else if (lx_ff[PSUM_W-1:PSUM_W-8] == 8'd0) begin
               lx_in = lx_ff << 8;
               le_in = le_ff - 6'd8;
            end else begin
               lx_in = lx_ff << 1;
               le_in = le_ff - 6'd1;
            end
         end
         M_SQR: begin
            frac_in = frac_next;
            y_in    = yn[32] ? yn[32:1] : yn[31:0];
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               res_in  = PROD_W'({le_ff, frac_next});
               done_in = 1'b1;
            end
         end
         M_MUL_HI: begin
            res_in  = prod_ff + (PROD_W'(pp) << MUL_HALF_W);
            done_in = 1'b1;
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      lx_ff    <= lx_in;
      le_ff    <= le_in;
      y_ff     <= y_in;
      frac_ff  <= frac_in;
      ma_ff    <= ma_in;
      mb_hi_ff <= mb_hi_in;
      prod_ff  <= prod_in;
      res_ff   <= res_in;
   end

   // A completion pulse only comes once the unit is free again.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (phase_ff == M_IDLE))
      else $error("math unit signals done while busy");

   // The squaring mantissa always stays normalized to one or more.
   a_sqr_norm: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == M_SQR) |-> y_ff[31])
      else $error("log mantissa lost its leading one");

   // The partial remainder of a division stays below the divisor.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == M_DIV) |-> (rem_ff < den_ff))
      else $error("division remainder reached the divisor");

endmodule

// File: rtl/core/column_pair_js_divergence_top.sv
// ----------------------------------------------------------------------------
// column_pair_js_divergence_top
// Stores a matrix and returns the Jensen-Shannon divergence of two columns.
// ----------------------------------------------------------------------------
// A load is written into the store when accepted and the next item is accepted right after.
// A query with a column out of range goes from the range check straight to
// the result state. Otherwise a query first sums both columns over the rows
// in use, then works out the divergence row by row (a row where both column
// totals are zero skips the arithmetic), its speed set by the one shared
// divider, logarithm and multiplier unit and the single RAM port.
// Reset clears control state and registers; the store is undefined until
// written and has no clearing pass.
module column_pair_js_divergence_top #(
   parameter int MAX_ROWS = cpjs_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = cpjs_pkg::MAX_COLS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic [cpjs_pkg::ROW_IDX_W-1:0]   req_row_index,
   input  logic [cpjs_pkg::COL_IDX_W-1:0]   req_column_a,
   input  logic [cpjs_pkg::COL_IDX_W-1:0]   req_column_b,
   input  logic [cpjs_pkg::VALUE_W-1:0]     req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cpjs_pkg::DIV_OUT_W-1:0]   rsp_divergence,
   output logic                             rsp_status,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cpjs_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [cpjs_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [cpjs_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   import cpjs_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int RCW   = $clog2(MAX_ROWS + 1);
   localparam logic [ACC_W-1:0] ACC_CLIP = ACC_W'(64'h4_0000_0000);

   state_type state_ff, state_in;
   logic [ROWS_W-1:0] rows_ff, rows_in;
   logic [COLS_W-1:0] cols_ff, cols_in;
   logic [PSEUDO_W-1:0] pseudo_ff, pseudo_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [DIV_OUT_W-1:0] rsp_div_ff, rsp_div_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [COL_IDX_W-1:0] ca_ff, ca_in;
   logic [COL_IDX_W-1:0] cb_ff, cb_in;
   logic [RW-1:0] row_ff, row_in;
   logic [RCW-1:0] rows_eff_ff, rows_eff_in;
   logic [SUM_W-1:0] ta_ff, ta_in;
   logic [SUM_W-1:0] tb_ff, tb_in;
   logic [NUM_W-1:0] na_ff, na_in;
   logic [NUM_W-1:0] nb_ff, nb_in;
   logic [PROB_W-1:0] p_ff, p_in;
   logic [PROB_W-1:0] q_ff, q_in;
   logic [LOG_W-1:0] ls_ff, ls_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic side_ff, side_in;
   logic neg_ff, neg_in;
   logic [DIV_OUT_W-1:0] res_ff, res_in;
   status_type stat_ff, stat_in;

   logic accept;
   logic csr_write;
   logic load_ok;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] addr_a;
   logic [AW-1:0] addr_b;
   logic [AW-1:0] rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic [31:0] cols_lim;
   logic [31:0] rows_lim;
   logic range_err;
   logic last_row;
   logic [NUM_W-1:0] rdv;
   logic [SUM_W:0] ta_sum;
   logic [SUM_W:0] tb_sum;
   logic [SUM_W-1:0] ta_add;
   logic [SUM_W-1:0] tb_add;
   logic [PSUM_W-1:0] s_sum;
   logic [PROB_W-1:0] pv;
   logic [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0] d_abs;
   logic [PROD_W-33:0] mag;
   logic acc_pos;
   logic [ACC_W-1:0] acc_clip;
   logic [PROD_W-34:0] fin;
   logic [DIV_OUT_W-1:0] fin_sat;
   logic [SUM_W-1:0] den;

   math_req_type math_req;
   math_rsp_type math_rsp;
   logic [SUM_W-1:0] math_opa;
   logic [SUM_W-1:0] math_opb;
   logic [PROD_W-1:0] math_res;

   // Matrix store.
   cpjs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared arithmetic unit.
   cpjs_math u_math (
      .clock  (clock),
      .reset  (reset),
      .req    (math_req),
      .opa    (math_opa),
      .opb    (math_opb),
      .rsp    (math_rsp),
      .result (math_res)
   );

   // Handshakes, addresses and limits.
   always_comb begin
      accept    = req_valid && req_ready;
      csr_write = psel && penable && pwrite && pready;
      load_ok   = accept && (req_cmd == CMD_LOAD)
                  && (32'(req_row_index) < 32'(MAX_ROWS))
                  && (32'(req_column_a) < 32'(MAX_COLS));
      wr_addr   = AW'(req_row_index) * AW'(MAX_COLS) + AW'(req_column_a);
      addr_a    = AW'(row_ff) * AW'(MAX_COLS) + AW'(ca_ff);
      addr_b    = AW'(row_ff) * AW'(MAX_COLS) + AW'(cb_ff);
      cols_lim  = (32'(cols_ff) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(cols_ff);
      rows_lim  = (32'(rows_ff) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(rows_ff);
      range_err = (32'(ca_ff) >= cols_lim) || (32'(cb_ff) >= cols_lim);
      last_row  = ((RCW'(row_ff) + RCW'(1)) == rows_eff_ff);
   end

   // Arithmetic around the shared unit.
   always_comb begin
      rdv      = NUM_W'(rd_data) + NUM_W'(pseudo_ff);
      ta_sum   = {1'b0, ta_ff} + (SUM_W + 1)'(rdv);
      tb_sum   = {1'b0, tb_ff} + (SUM_W + 1)'(rdv);
      ta_add   = ta_sum[SUM_W] ? '1 : ta_sum[SUM_W-1:0];
      tb_add   = tb_sum[SUM_W] ? '1 : tb_sum[SUM_W-1:0];
      s_sum    = PSUM_W'(p_ff) + PSUM_W'(q_ff);
      pv       = side_ff ? q_ff : p_ff;
      den      = side_ff ? tb_ff : ta_ff;
      // Log ratio 1 + log2(p) - log2(s), in Q.32.
      diff     = DIFF_W'(64'h1_0000_0000) + DIFF_W'(math_res[LOG_W-1:0]) - DIFF_W'(ls_ff);
      d_abs    = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      mag      = math_res[PROD_W-1:32];
      acc_pos  = !acc_ff[ACC_W-1] && (acc_ff != '0);
      acc_clip = (acc_ff > ACC_CLIP) ? ACC_CLIP : acc_ff;
      fin      = math_res[PROD_W-1:33];
      fin_sat  = (fin[PROD_W-34:32] != '0) ? '1 : fin[31:0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_cmd == CMD_QUERY)) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (range_err) begin
               state_in = S_RESULT;
            end else if (rows_lim == 32'd0) begin
               state_in = S_FIN_GO;
            end else begin
               state_in = S_SUM_RD_A;
            end
         end
         S_SUM_RD_A: state_in = S_SUM_RD_B;
         S_SUM_RD_B: state_in = S_SUM_CAP;
         S_SUM_CAP:  state_in = last_row ? S_P2_RD_A : S_SUM_RD_A;
         S_P2_RD_A:  state_in = S_P2_RD_B;
         S_P2_RD_B:  state_in = S_P2_CAP;
         S_P2_CAP:   state_in = S_DIV_GO;
         S_DIV_GO: begin
            if (den != '0) begin
               state_in = S_DIV_WAIT;
            end else begin
               state_in = side_ff ? S_LOGS_GO : S_DIV_GO;
            end
         end
         S_DIV_WAIT: begin
            if (math_rsp.done) begin
               state_in = side_ff ? S_LOGS_GO : S_DIV_GO;
            end
         end
         S_LOGS_GO: state_in = (s_sum == '0) ? S_ROW_NEXT : S_LOGS_WAIT;
         S_LOGS_WAIT: begin
            if (math_rsp.done) begin
               state_in = S_TERM_GO;
            end
         end
         S_TERM_GO: begin
            if (pv != '0) begin
               state_in = S_TERM_LOG_WAIT;
            end else begin
               state_in = side_ff ? S_ROW_NEXT : S_TERM_GO;
            end
         end
         S_TERM_LOG_WAIT: begin
            if (math_rsp.done) begin
               state_in = S_TERM_MUL_WAIT;
            end
         end
         S_TERM_MUL_WAIT: begin
            if (math_rsp.done) begin
               state_in = side_ff ? S_ROW_NEXT : S_TERM_GO;
            end
         end
         S_ROW_NEXT: state_in = last_row ? S_FIN_GO : S_P2_RD_A;
         S_FIN_GO:   state_in = acc_pos ? S_FIN_WAIT : S_RESULT;
         S_FIN_WAIT: begin
            if (math_rsp.done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs of the state machine: RAM address and arithmetic requests.
   always_comb begin
      req_ready      = (state_ff == S_IDLE);
      rd_addr        = addr_a;
      math_req.start = 1'b0;
      math_req.op    = MATH_DIV;
      math_opa       = '0;
      math_opb       = '0;
      unique case (state_ff)
         S_SUM_RD_B, S_P2_RD_B: begin
            rd_addr = addr_b;
         end
         S_DIV_GO: begin
            math_req.start = (den != '0);
            math_req.op    = MATH_DIV;
            math_opa       = side_ff ? SUM_W'(nb_ff) : SUM_W'(na_ff);
            math_opb       = den;
         end
         S_LOGS_GO: begin
            math_req.start = (s_sum != '0);
            math_req.op    = MATH_LOG;
            math_opa       = SUM_W'(s_sum);
         end
         S_TERM_GO: begin
            math_req.start = (pv != '0);
            math_req.op    = MATH_LOG;
            math_opa       = SUM_W'(pv);
         end
         S_TERM_LOG_WAIT: begin
            math_req.start = math_rsp.done;
            math_req.op    = MATH_MUL;
            math_opa       = SUM_W'(pv);
            math_opb       = SUM_W'(d_abs);
         end
         S_FIN_GO: begin
            math_req.start = acc_pos;
            math_req.op    = MATH_MUL;
            math_opa       = SUM_W'(LN2_Q32);
            math_opb       = acc_clip;
         end
         default: begin
            rd_addr = addr_a;
         end
      endcase
   end

   // Datapath and configuration updates.
   always_comb begin
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      pseudo_in     = pseudo_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_div_in    = rsp_div_ff;
      rsp_status_in = rsp_status_ff;
      ca_in         = ca_ff;
      cb_in         = cb_ff;
      row_in        = row_ff;
      rows_eff_in   = rows_eff_ff;
      ta_in         = ta_ff;
      tb_in         = tb_ff;
      na_in         = na_ff;
      nb_in         = nb_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      ls_in         = ls_ff;
      acc_in        = acc_ff;
      side_in       = side_ff;
      neg_in        = neg_ff;
      res_in        = res_ff;
      stat_in       = stat_ff;

      // Register writes; codes past the list are ignored.
      if (csr_write) begin
         unique case (csr_index_type'(paddr[3:2]))
            CSR_ROWS:   rows_in   = pwdata[ROWS_W-1:0];
            CSR_COLS:   cols_in   = pwdata[COLS_W-1:0];
            CSR_PSEUDO: pseudo_in = pwdata[PSEUDO_W-1:0];
            default:    rows_in   = rows_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_cmd == CMD_QUERY)) begin
               ca_in = req_column_a;
               cb_in = req_column_b;
            end
         end
         S_CHECK: begin
            row_in      = '0;
            rows_eff_in = RCW'(rows_lim);
            ta_in       = '0;
            tb_in       = '0;
            acc_in      = '0;
            side_in     = 1'b0;
            res_in      = '0;
            stat_in     = range_err ? STATUS_RANGE : STATUS_OK;
         end
         S_SUM_RD_B: ta_in = ta_add;
         S_SUM_CAP: begin
            tb_in  = tb_add;
            row_in = last_row ? '0 : RW'(row_ff + RW'(1));
         end
         S_P2_RD_B: na_in = rdv;
         S_P2_CAP: begin
            nb_in   = rdv;
            side_in = 1'b0;
         end
         S_DIV_GO: begin
            // An empty column gives zero probability everywhere.
            if (den == '0) begin
               if (side_ff) begin
                  q_in = '0;
               end else begin
                  p_in = '0;
               end
               side_in = !side_ff;
            end
         end
         S_DIV_WAIT: begin
            if (math_rsp.done) begin
               if (side_ff) begin
                  q_in = math_res[PROB_W-1:0];
               end else begin
                  p_in = math_res[PROB_W-1:0];
               end
               side_in = !side_ff;
            end
         end
         S_LOGS_WAIT: begin
            if (math_rsp.done) begin
               ls_in = math_res[LOG_W-1:0];
            end
         end
         S_TERM_GO: begin
            if (pv == '0) begin
               side_in = !side_ff;
            end
         end
         S_TERM_LOG_WAIT: begin
            if (math_rsp.done) begin
               neg_in = diff[DIFF_W-1];
            end
         end
         S_TERM_MUL_WAIT: begin
            if (math_rsp.done) begin
               acc_in  = neg_ff ? (acc_ff - ACC_W'(mag)) : (acc_ff + ACC_W'(mag));
               side_in = !side_ff;
            end
         end
         S_ROW_NEXT: row_in = RW'(row_ff + RW'(1));
         S_FIN_WAIT: begin
            if (math_rsp.done) begin
               res_in = fin_sat;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_div_in    = res_ff;
               rsp_status_in = stat_ff;
            end
         end
         default: begin
            side_in = side_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rows_ff      <= ROWS_RESET;
         cols_ff      <= COLS_RESET;
         pseudo_ff    <= PSEUDO_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         pseudo_ff    <= pseudo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_div_ff    <= rsp_div_in;
      rsp_status_ff <= rsp_status_in;
      ca_ff         <= ca_in;
      cb_ff         <= cb_in;
      row_ff        <= row_in;
      rows_eff_ff   <= rows_eff_in;
      ta_ff         <= ta_in;
      tb_ff         <= tb_in;
      na_ff         <= na_in;
      nb_ff         <= nb_in;
      p_ff          <= p_in;
      q_ff          <= q_in;
      ls_ff         <= ls_in;
      acc_ff        <= acc_in;
      side_ff       <= side_in;
      neg_ff        <= neg_in;
      res_ff        <= res_in;
      stat_ff       <= stat_in;
   end

   // Port drivers and register read back.
   always_comb begin
      rsp_valid      = rsp_valid_ff;
      rsp_divergence = rsp_div_ff;
      rsp_status     = rsp_status_ff;
      pready         = 1'b1;
      unique case (csr_index_type'(paddr[3:2]))
         CSR_ROWS:   prdata = CSR_DATA_W'(rows_ff);
         CSR_COLS:   prdata = CSR_DATA_W'(cols_ff);
         CSR_PSEUDO: prdata = CSR_DATA_W'(pseudo_ff);
         default:    prdata = '0;
      endcase
   end

   // An accepted query always starts with the column range check.
   a_query_check: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_QUERY)) |=> (state_ff == S_CHECK))
      else $error("query transfer did not start the range check");

   // A range error result carries a zero divergence.
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_RANGE)) |-> (rsp_div_ff == '0))
      else $error("range error result with nonzero divergence");

   // The arithmetic unit is only started while it is free.
   a_math_free: assert property (@(posedge clock) disable iff (reset)
      math_req.start |-> !math_rsp.busy)
      else $error("arithmetic unit started while busy");

   // Row reads stay within the rows in use.
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SUM_RD_A) || (state_ff == S_P2_RD_A))
         |-> (RCW'(row_ff) < rows_eff_ff))
      else $error("row counter past the rows in use");

endmodule
